// ===== rtl/core/xsr_pkg.sv =====
package xsr_pkg;

    // Item codes
    localparam logic ACT_DRAW   = 1'b0;
    localparam logic ACT_RESEED = 1'b1;

    // Register map: one 64-bit register, index taken from paddr[3]
    localparam int  PADDR_W       = 4;
    localparam int  PDATA_W       = 64;
    localparam int  REG_IDX_BIT   = 3;
    localparam logic REG_IDX_SEED = 1'b0;

    // splitmix64 constants
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_C1       = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2       = 64'h94d049bb133111eb;
    localparam int          SM_SHIFT_A   = 30;
    localparam int          SM_SHIFT_B   = 27;
    localparam int          SM_SHIFT_C   = 31;

    // xoshiro256++ rotate / shift amounts
    localparam int XO_ROT_OUT = 23;
    localparam int XO_SHIFT   = 17;
    localparam int XO_ROT_S3  = 45;

    localparam int FRAC_W = 53;
    localparam int PROB_W = 54;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ADD,
        ST_MUL_LL,
        ST_MUL_LH,
        ST_MUL_HL,
        ST_MUL_ACC,
        ST_MIX,
        ST_DONE
    } t_state;

    // which 32x32 partial product of the 64x64 low-half multiply
    typedef enum logic [1:0] {
        PART_LL,
        PART_LH,
        PART_HL
    } t_mul_part;

    typedef struct packed {
        logic      load_seed;   // acc <= seed (or zero during boot)
        logic      use_zero;
        logic      add_gold;    // acc += gamma, z <= mix30(acc)
        logic      mul_en;      // pp <= partial product
        t_mul_part mul_part;
        logic      acc_first;   // prod <= pp
        logic      acc_cross;   // prod += pp << 32
        logic      mix;         // round 0: z <= mix27(prod); round 1: store mix31(prod)
        logic      round;
        logic [1:0] word_idx;
        logic      fix_sum;     // sum <= s0 + s3
        logic      draw;
        logic      ack_reseed;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_stat;

endpackage

// ===== rtl/core/xsr_regs.sv =====
module xsr_regs
    import xsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [63:0]        o_seed
);

    logic [63:0] r_seed;
    logic        w_hit_seed;

    assign w_hit_seed = (paddr[REG_IDX_BIT] == REG_IDX_SEED);
    assign pready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (psel && penable && pwrite && pready && w_hit_seed) begin
            r_seed <= pwdata;
        end
    end

    assign prdata = w_hit_seed ? r_seed : '0;
    assign o_seed = r_seed;

endmodule

// ===== rtl/core/xsr_ctrl.sv =====
module xsr_ctrl
    import xsr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_action,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_word, n_word;
    logic       r_round, n_round;
    logic       r_boot, n_boot;
    logic       w_out_free;

    assign w_out_free = !i_stat.out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_word  <= '0;
            r_round <= 1'b0;
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_round <= n_round;
            r_boot  <= n_boot;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_word         = r_word;
        n_round        = r_round;
        n_boot         = r_boot;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.round    = r_round;
        o_cmd.word_idx = r_word;
        o_cmd.mul_part = PART_LL;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = w_out_free;
                if (i_in_valid && w_out_free) begin
                    if (i_action == ACT_RESEED) begin
                        n_state = ST_LOAD;
                    end else begin
                        o_cmd.draw = 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load_seed = 1'b1;
                o_cmd.use_zero  = r_boot;
                n_word          = '0;
                n_state         = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add_gold = 1'b1;
                n_round        = 1'b0;
                n_state        = ST_MUL_LL;
            end
            ST_MUL_LL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_part = PART_LL;
                n_state        = ST_MUL_LH;
            end
            ST_MUL_LH: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_part  = PART_LH;
                o_cmd.acc_first = 1'b1;
                n_state         = ST_MUL_HL;
            end
            ST_MUL_HL: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_part  = PART_HL;
                o_cmd.acc_cross = 1'b1;
                n_state         = ST_MUL_ACC;
            end
            ST_MUL_ACC: begin
                o_cmd.acc_cross = 1'b1;
                n_state         = ST_MIX;
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
                if (!r_round) begin
                    n_round = 1'b1;
                    n_state = ST_MUL_LL;
                end else if (r_word == 2'd3) begin
                    n_state = ST_DONE;
                end else begin
                    n_word  = r_word + 2'd1;
                    n_state = ST_ADD;
                end
            end
            ST_DONE: begin
                o_cmd.fix_sum = 1'b1;
                if (r_boot) begin
                    n_boot  = 1'b0;
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    o_cmd.ack_reseed = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_reseed_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && o_in_ready && i_action == ACT_RESEED)
        |=> (r_state == ST_LOAD))
        else $error("reseed transfer did not start expansion");

    a_boot_done_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_boot)
        else $error("idle reached with boot expansion pending");

    a_ack_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ack_reseed |-> (w_out_free && !r_boot))
        else $error("reseed result issued without output room");

endmodule

// ===== rtl/core/xsr_dpath.sv =====
module xsr_dpath
    import xsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [63:0]       i_seed,
    input  logic [PROB_W-1:0] i_probability,
    input  logic              i_out_ready,
    output t_dp_stat          o_stat,
    output logic              o_out_valid,
    output logic [63:0]       o_raw_value,
    output logic [FRAC_W-1:0] o_fraction_bits,
    output logic              o_bernoulli_hit,
    output logic              o_reseeded
);

    // generator state, plus s0 + s3 kept ready for the next draw
    logic [63:0] r_s [4];
    logic [63:0] r_sum;

    // splitmix64 working registers
    logic [63:0] r_acc, r_z, r_pp, r_prod;

    // output register
    logic              r_out_valid;
    logic [63:0]       r_raw;
    logic [PROB_W-1:0] r_prob;
    logic              r_reseeded;

    logic [63:0] w_gold_sum, w_const;
    logic [31:0] w_mul_a, w_mul_b;
    logic [63:0] w_pp;
    logic [63:0] w_rot, w_res, w_t;
    logic [63:0] n_s0, n_s1, n_s2, n_s3;

    // ---- splitmix64 ----
    assign w_gold_sum = r_acc + GOLDEN_GAMMA;
    assign w_const    = i_cmd.round ? MIX_C2 : MIX_C1;

    always_comb begin
        case (i_cmd.mul_part)
            PART_LL: begin
                w_mul_a = r_z[31:0];
                w_mul_b = w_const[31:0];
            end
            PART_LH: begin
                w_mul_a = r_z[31:0];
                w_mul_b = w_const[63:32];
            end
            PART_HL: begin
                w_mul_a = r_z[63:32];
                w_mul_b = w_const[31:0];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_pp = w_mul_a * w_mul_b;

    // ---- xoshiro256++ step ----
    assign w_rot = {r_sum[63-XO_ROT_OUT:0], r_sum[63:64-XO_ROT_OUT]};
    assign w_res = w_rot + r_s[0];
    assign w_t   = r_s[1] << XO_SHIFT;
    assign n_s2  = r_s[2] ^ r_s[0] ^ w_t;
    assign n_s1  = r_s[1] ^ r_s[2] ^ r_s[0];
    assign n_s0  = r_s[0] ^ r_s[3] ^ r_s[1];
    assign n_s3  = {(r_s[3][63-XO_ROT_S3:0] ^ r_s[1][63-XO_ROT_S3:0]),
                    (r_s[3][63:64-XO_ROT_S3] ^ r_s[1][63:64-XO_ROT_S3])};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seed) begin
            r_acc <= i_cmd.use_zero ? '0 : i_seed;
        end else if (i_cmd.add_gold) begin
            r_acc <= w_gold_sum;
        end
        if (i_cmd.add_gold) begin
            r_z <= w_gold_sum ^ (w_gold_sum >> SM_SHIFT_A);
        end else if (i_cmd.mix && !i_cmd.round) begin
            r_z <= r_prod ^ (r_prod >> SM_SHIFT_B);
        end
        if (i_cmd.mul_en) begin
            r_pp <= w_pp;
        end
        if (i_cmd.acc_first) begin
            r_prod <= r_pp;
        end else if (i_cmd.acc_cross) begin
            r_prod <= r_prod + {r_pp[31:0], 32'b0};
        end
        if (i_cmd.draw) begin
            r_s[0] <= n_s0;
            r_s[1] <= n_s1;
            r_s[2] <= n_s2;
            r_s[3] <= n_s3;
            r_sum  <= n_s0 + n_s3;
        end else begin
            if (i_cmd.mix && i_cmd.round) begin
                r_s[i_cmd.word_idx] <= r_prod ^ (r_prod >> SM_SHIFT_C);
            end
            if (i_cmd.fix_sum) begin
                r_sum <= r_s[0] + r_s[3];
            end
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.draw || i_cmd.ack_reseed) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.draw) begin
            r_raw      <= w_res;
            r_prob     <= i_probability;
            r_reseeded <= 1'b0;
        end else if (i_cmd.ack_reseed) begin
            r_raw      <= '0;
            r_prob     <= '0;
            r_reseeded <= 1'b1;
        end
    end

    assign o_stat.out_valid = r_out_valid;
    assign o_out_valid      = r_out_valid;
    assign o_raw_value      = r_raw;
    assign o_fraction_bits  = r_raw[63:64-FRAC_W];
    assign o_bernoulli_hit  = ({1'b0, r_raw[63:64-FRAC_W]} < r_prob);
    assign o_reseeded       = r_reseeded;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.draw || i_cmd.ack_reseed) |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

    a_reseed_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_reseeded) |-> (r_raw == '0 && r_prob == '0))
        else $error("reseed result carries draw data");

endmodule

// ===== rtl/core/xoshiro256pp_random_generator.sv =====
// Channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------------------
// in       | i_in_valid / o_in_ready    | i_action, i_probability
// out      | o_out_valid / i_out_ready  | o_raw_value, o_fraction_bits,
//          |                            | o_bernoulli_hit, o_reseeded
// config   | psel, penable, pwrite      | paddr, pwdata, prdata (seed at 0x0)
//
// Draw: one transfer per cycle while the output is free; the result lands in the
//   output register the next cycle. Reseed: 4 splitmix64 rounds on one 32x32
//   multiplier, plus load and finish; input ready is low meanwhile.
// Reset: the same expansion runs on seed zero, no result is produced.
// A stalled output holds the result; the input is ready again in the cycle it is taken.
module xoshiro256pp_random_generator
    import xsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic [PROB_W-1:0]  i_probability,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [63:0]        o_raw_value,
    output logic [FRAC_W-1:0]  o_fraction_bits,
    output logic               o_bernoulli_hit,
    output logic               o_reseeded,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [63:0] w_seed;
    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;

    // seed register
    xsr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_seed  (w_seed)
    );

    // sequencer: draws issue straight from idle, reseeds walk the multiply steps
    xsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (w_cmd)
    );

    // state words, splitmix64 unit and output register
    xsr_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_seed          (w_seed),
        .i_probability   (i_probability),
        .i_out_ready     (i_out_ready),
        .o_stat          (w_stat),
        .o_out_valid     (o_out_valid),
        .o_raw_value     (o_raw_value),
        .o_fraction_bits (o_fraction_bits),
        .o_bernoulli_hit (o_bernoulli_hit),
        .o_reseeded      (o_reseeded)
    );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import xsr_pkg::*;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int IDLE_PCT        = 7;     // chance of a gap on either side, per hundred
    localparam int NUM_PHASES      = 6;     // random phases, each starts from a fresh seed
    localparam int ITEMS_PER_PHASE = 320;
    localparam int CALM_PHASE      = 2;     // this phase runs with no gaps on either side
    localparam int RESEED_PCT      = 5;     // reseeds hold the input for the whole expansion, keep them rare
    localparam int MAX_REPORTS     = 10;
    localparam int DRAIN_CYCLES    = 60;    // one reseed latency plus margin
    localparam int STALL_LIMIT     = 2000;  // cycles with no transfer before giving up

    // Probability scale: 2^53 means "always hit"
    localparam logic [PROB_W-1:0] FULL_SCALE = 54'h20_0000_0000_0000;
    localparam logic [PROB_W-1:0] PROB_MAX   = 54'h3F_FFFF_FFFF_FFFF;

    // Register map: 64-bit registers at 8-byte strides, only index 0 exists
    localparam logic [PADDR_W-1:0] ADDR_SEED  = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_SPARE = 4'h8;

    // splitmix64 / xoshiro256++ constants, kept locally for the predictor
    localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;

    typedef struct packed {
        logic [63:0]       raw;
        logic [FRAC_W-1:0] frac;
        logic              hit;
        logic              reseeded;
    } t_result;

    localparam t_result NO_EXP     = '0;
    localparam t_result RESEED_ACK = '{raw: 64'd0, frac: 53'd0, hit: 1'b0, reseeded: 1'b1};

    // Directed stimulus table. ROW_ITEM rows with fixed set carry their
    // expected result inline; all other items go through the predictor.
    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_WRITE,
        ROW_READ
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic               act;
        logic [PROB_W-1:0]  prob;
        logic [PADDR_W-1:0] addr;
        logic [PDATA_W-1:0] data;
        logic               fixed;
        t_result            exp;
    } t_row;

    localparam int NUM_DIR = 25;
    t_row dir_rows [NUM_DIR] = '{
        // draws straight out of the boot state (seed zero expansion)
        '{ROW_ITEM,  ACT_DRAW,   54'd0,                ADDR_SEED, 64'd0, 1'b0, NO_EXP},
        '{ROW_ITEM,  ACT_DRAW,   FULL_SCALE,           ADDR_SEED, 64'd0, 1'b0, NO_EXP},
        '{ROW_ITEM,  ACT_DRAW,   PROB_MAX,             ADDR_SEED, 64'd0, 1'b0, NO_EXP},
        '{ROW_ITEM,  ACT_DRAW,   54'd1,                ADDR_SEED, 64'd0, 1'b0, NO_EXP},
        '{ROW_ITEM,  ACT_DRAW,   54'h1F_FFFF_FFFF_FFFF, ADDR_SEED, 64'd0, 1'b0, NO_EXP},
        '{ROW_ITEM,  ACT_DRAW,   54'h10_0000_0000_0000, ADDR_SEED, 64'd0, 1'b0, NO_EXP},
        // reseed from the reset seed: sequence restarts from the boot state
        '{ROW_ITEM,  ACT_RESEED, 54'd0,                ADDR_SEED, 64'd0, 1'b1, RESEED_ACK},
        '{ROW_ITEM,  ACT_DRAW,   FULL_SCALE,           ADDR_SEED, 64'd0, 1'b0, NO_EXP},
        '{ROW_READ,  ACT_DRAW,   54'd0,                ADDR_SEED, 64'd0, 1'b0, NO_EXP},
        // all-ones seed
        '{ROW_WRITE, ACT_DRAW,   54'd0,                ADDR_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_EXP},
        '{ROW_READ,  ACT_DRAW,   54'd0,                ADDR_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_EXP},
        '{ROW_ITEM,  ACT_RESEED, PROB_MAX,             ADDR_SEED, 64'd0, 1'b1, RESEED_ACK},
        '{ROW_ITEM,  ACT_DRAW,   54'd0,                ADDR_SEED, 64'd0, 1'b0, NO_EXP},
        '{ROW_ITEM,  ACT_DRAW,   FULL_SCALE,           ADDR_SEED, 64'd0, 1'b0, NO_EXP},
        '{ROW_ITEM,  ACT_DRAW,   54'h10_0000_0000_0000, ADDR_SEED, 64'd0, 1'b0, NO_EXP},
        // write past the register list is dropped; the reseed still uses all-ones
        '{ROW_WRITE, ACT_DRAW,   54'd0,                ADDR_SPARE, 64'h1234_5678_9ABC_DEF0, 1'b0, NO_EXP},
        '{ROW_ITEM,  ACT_RESEED, 54'd0,                ADDR_SEED, 64'd0, 1'b1, RESEED_ACK},
        '{ROW_ITEM,  ACT_DRAW,   54'h2A_AAAA_AAAA_AAAA, ADDR_SEED, 64'd0, 1'b0, NO_EXP},
        '{ROW_ITEM,  ACT_DRAW,   54'h15_5555_5555_5555, ADDR_SEED, 64'd0, 1'b0, NO_EXP},
        // seed one, back-to-back reseeds
        '{ROW_WRITE, ACT_DRAW,   54'd0,                ADDR_SEED, 64'd1, 1'b0, NO_EXP},
        '{ROW_ITEM,  ACT_RESEED, FULL_SCALE,           ADDR_SEED, 64'd0, 1'b1, RESEED_ACK},
        '{ROW_ITEM,  ACT_RESEED, 54'd0,                ADDR_SEED, 64'd0, 1'b1, RESEED_ACK},
        '{ROW_ITEM,  ACT_DRAW,   FULL_SCALE,           ADDR_SEED, 64'd0, 1'b0, NO_EXP},
        '{ROW_ITEM,  ACT_DRAW,   54'd0,                ADDR_SEED, 64'd0, 1'b0, NO_EXP},
        '{ROW_READ,  ACT_DRAW,   54'd0,                ADDR_SEED, 64'd1, 1'b0, NO_EXP}
    };

    // ------------------------------------------------------------------
    // DUT hookup; every input starts from a known value
    // ------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_action = ACT_DRAW;
    logic [PROB_W-1:0]  i_probability = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [63:0]        o_raw_value;
    logic [FRAC_W-1:0]  o_fraction_bits;
    logic               o_bernoulli_hit;
    logic               o_reseeded;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    xoshiro256pp_random_generator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_probability   (i_probability),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_raw_value     (o_raw_value),
        .o_fraction_bits (o_fraction_bits),
        .o_bernoulli_hit (o_bernoulli_hit),
        .o_reseeded      (o_reseeded),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Generator predictor: own copy of the state words and seed register
    // ------------------------------------------------------------------
    logic [63:0] xo_state [4];
    logic [63:0] seed_shadow = 64'd0;
    t_result     xo_pending [$];     // predicted results, oldest first
    bit          calm = 1'b0;        // no gaps on either side while set
    int          mismatches = 0;     // owned by the result checker
    int          reg_errs = 0;       // owned by the stimulus process
    t_result     want;
    int          quiet_cycles = 0;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
        return (v << r) | (v >> (64 - r));
    endfunction

    // four splitmix64 rounds fill the state words
    function automatic void xo_expand(input logic [63:0] seed);
        logic [63:0] acc;
        logic [63:0] z;
        acc = seed;
        for (int w = 0; w < 4; w++) begin
            acc = acc + SM_GAMMA;
            z = acc;
            z = (z ^ (z >> 30)) * SM_MUL1;
            z = (z ^ (z >> 27)) * SM_MUL2;
            xo_state[w] = z ^ (z >> 31);
        end
    endfunction

    // result of one item, state updated as a side effect
    function automatic t_result xo_step(input logic act, input logic [PROB_W-1:0] prob);
        t_result     r;
        logic [63:0] s0, s1, s2, s3, t;
        if (act == ACT_RESEED) begin
            xo_expand(seed_shadow);
            r = RESEED_ACK;
        end else begin
            s0 = xo_state[0];
            s1 = xo_state[1];
            s2 = xo_state[2];
            s3 = xo_state[3];
            r.raw      = rotl64(s0 + s3, 23) + s0;
            r.frac     = r.raw[63:11];
            r.hit      = ({1'b0, r.frac} < prob);
            r.reseeded = 1'b0;
            t  = s1 << 17;
            s2 = s2 ^ s0;
            s3 = s3 ^ s1;
            s1 = s1 ^ s2;
            s0 = s0 ^ s3;
            s2 = s2 ^ t;
            s3 = rotl64(s3, 45);
            xo_state[0] = s0;
            xo_state[1] = s1;
            xo_state[2] = s2;
            xo_state[3] = s3;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side. Tasks are entered just after a rising edge; valid stays
    // high across back-to-back items and only drops for a gap or in wait_idle.
    // ------------------------------------------------------------------
    task automatic send_item(input logic act, input logic [PROB_W-1:0] prob,
                             input logic fixed, input t_result exp);
        t_result pred;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_probability <= prob;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        // transfer happened at this edge
        pred = xo_step(act, prob);
        xo_pending.push_back(fixed ? exp : pred);
    endtask

    // config is only touched with nothing in flight
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (xo_pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        // write lands here; anything past the register list is dropped
        if (addr == ADDR_SEED) seed_shadow = data;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] expv);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== expv) begin
            reg_errs++;
            $display("register read at %h: expected %h, got %h", addr, expv, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random backpressure, then field-by-field check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (xo_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing pending: %s%h frac=%h hit=%b reseeded=%b",
                             $realtime, "raw=", o_raw_value, o_fraction_bits,
                             o_bernoulli_hit, o_reseeded);
            end else begin
                want = xo_pending.pop_front();
                if (o_raw_value !== want.raw || o_fraction_bits !== want.frac ||
                    o_bernoulli_hit !== want.hit || o_reseeded !== want.reseeded) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: expected raw=%h frac=%h hit=%b reseeded=%b, ",
                                  "got raw=%h frac=%h hit=%b reseeded=%b"},
                                 $realtime, want.raw, want.frac, want.hit, want.reseeded,
                                 o_raw_value, o_fraction_bits, o_bernoulli_hit, o_reseeded);
                end
            end
        end
    end

    // Watchdog: a reseed (or the boot expansion) is the longest legal quiet spell
    always @(posedge i_clk) begin
        if (!i_rst_n || (psel && penable && pready === 1'b1) ||
            (i_in_valid && o_in_ready === 1'b1) ||
            (o_out_valid === 1'b1 && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results pending",
                     quiet_cycles, xo_pending.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [PDATA_W-1:0] next_seed;
        logic [PROB_W-1:0]  prob;
        logic               act;

        xo_expand(64'd0);   // state after reset is the seed-zero expansion

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // boot expansion holds input ready low; send_item just waits on it

        // directed part
        for (int r = 0; r < NUM_DIR; r++) begin
            case (dir_rows[r].kind)
                ROW_ITEM: begin
                    send_item(dir_rows[r].act, dir_rows[r].prob,
                              dir_rows[r].fixed, dir_rows[r].exp);
                end
                ROW_WRITE: begin
                    wait_idle();
                    apb_write(dir_rows[r].addr, dir_rows[r].data);
                end
                default: begin
                    wait_idle();
                    apb_read_check(dir_rows[r].addr, dir_rows[r].data);
                end
            endcase
        end

        // random part: each phase loads a seed (extremes among them) and reseeds
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                1:       next_seed = 64'd0;
                3:       next_seed = 64'hFFFF_FFFF_FFFF_FFFF;
                4:       next_seed = 64'h8000_0000_0000_0000;
                default: next_seed = {$urandom, $urandom};
            endcase
            apb_write(ADDR_SEED, next_seed);
            apb_read_check(ADDR_SEED, next_seed);
            calm = (ph == CALM_PHASE);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(0, 15))
                    0, 1:    prob = '0;
                    2, 3:    prob = FULL_SCALE;
                    4, 5:    prob = PROB_W'({$urandom, $urandom});                  // may exceed 2^53
                    6:       prob = PROB_W'($urandom_range(0, 15));
                    7:       prob = FULL_SCALE - PROB_W'($urandom_range(0, 15));
                    default: prob = {1'b0, FRAC_W'({$urandom, $urandom})};
                endcase
                // first item of a phase picks up the new seed
                act = (n == 0 || $urandom_range(0, 99) < RESEED_PCT) ? ACT_RESEED : ACT_DRAW;
                send_item(act, prob, 1'b0, NO_EXP);
            end
        end
        calm = 1'b0;

        // drain, then give a stray extra result time to show up
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (xo_pending.size() != 0)
            $display("%0d expected results never arrived", xo_pending.size());
        if (mismatches == 0 && reg_errs == 0 && xo_pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
